// File: rtl/core/bbp_pkg.sv
// Shared types and constants for the bimodal two-bit branch predictor.
`timescale 1ns / 1ps

package bbp_pkg;

  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // Two-bit counter codes
  localparam logic [1:0] CTR_MIN       = 2'd0;
  localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
  localparam logic [1:0] CTR_MAX       = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } bbp_state_t;

  typedef struct packed {
    logic clear;   // write zero at the sweep address, advance it
    logic load;    // capture input word, read its counter
    logic update;  // write back counter, bump totals, load result
  } bbp_cmd_t;

  typedef struct packed {
    logic clear_last;  // sweep is at the last table entry
    logic out_busy;    // result register full and not taken this cycle
  } bbp_stat_t;

endpackage

// File: rtl/core/bbp_ctrl.sv
// Controller state machine: table clear sweep, input accept, update sequencing.
`timescale 1ns / 1ps

module bbp_ctrl import bbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  bbp_stat_t stat,
  output bbp_cmd_t  cmd
);

  bbp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!stat.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.load, cmd.update}))
    else $error("more than one datapath command at once");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !in_tready)
    else $error("input accepted during table clear");

  a_load_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load && !cmd.clear)
    else $error("new word loaded before previous one updated");

endmodule

// File: rtl/core/bbp_dp.sv
// Datapath: counter table memory, clear sweep, saturating totals, result register.
`timescale 1ns / 1ps

module bbp_dp import bbp_pkg::*; #(
  parameter int ENTRIES = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bbp_cmd_t               cmd,
  output bbp_stat_t              stat,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [1:0]       mem [ENTRIES];

  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             taken_r;
  logic [1:0]       ctr_r;
  logic [CNT_W-1:0] correct_cnt_r, correct_cnt_nxt;
  logic [CNT_W-1:0] branch_cnt_r, branch_cnt_nxt;
  logic             pred_r, ok_r;
  logic             out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0] in_idx;
  logic             pred, ok;
  logic [1:0]       ctr_new;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [1:0]       wr_data;

  assign in_idx = in_tdata[IDX_W-1:0];
  assign pred   = (ctr_r >= CTR_TAKEN_MIN);
  assign ok     = (pred == taken_r);

  always_comb begin
    if (taken_r) begin
      ctr_new = (ctr_r == CTR_MAX) ? CTR_MAX : ctr_r + 2'd1;
    end else begin
      ctr_new = (ctr_r == CTR_MIN) ? CTR_MIN : ctr_r - 2'd1;
    end
  end

  // Single write port, shared by the clear sweep and the counter update
  assign wr_en   = cmd.clear | cmd.update;
  assign wr_idx  = cmd.clear ? clr_idx_r : idx_r;
  assign wr_data = cmd.clear ? CTR_MIN : ctr_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.load) begin
      ctr_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= in_idx;
      taken_r <= in_tdata[ADDR_W];
    end
    if (cmd.update) begin
      pred_r <= pred;
      ok_r   <= ok;
    end
  end

  always_comb begin
    clr_idx_nxt     = cmd.clear ? clr_idx_r + IDX_W'(1) : clr_idx_r;
    correct_cnt_nxt = correct_cnt_r;
    branch_cnt_nxt  = branch_cnt_r;
    if (cmd.update) begin
      if (ok && !(&correct_cnt_r)) begin
        correct_cnt_nxt = correct_cnt_r + CNT_W'(1);
      end
      if (!(&branch_cnt_r)) begin
        branch_cnt_nxt = branch_cnt_r + CNT_W'(1);
      end
    end
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r     <= '0;
      correct_cnt_r <= '0;
      branch_cnt_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      clr_idx_r     <= clr_idx_nxt;
      correct_cnt_r <= correct_cnt_nxt;
      branch_cnt_r  <= branch_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign stat.clear_last = (clr_idx_r == IDX_W'(ENTRIES - 1));
  assign stat.out_busy   = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  // Totals registers hold until the next update, which waits for a free slot
  assign out_tdata  = {6'd0, branch_cnt_r, correct_cnt_r, ok_r, pred_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !(out_valid_r && !out_tready))
    else $error("result overwritten before it was taken");

  a_correct_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    correct_cnt_r <= branch_cnt_r)
    else $error("correct count exceeds branch count");

  a_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> branch_cnt_r != '0 && out_valid_r)
    else $error("update did not produce a result word");

endmodule

// File: rtl/core/bimodal_two_bit_predictor_top.sv
// Top level of the bimodal two-bit saturating counter branch predictor.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready   | in_tdata[40]: branch_address, branch_taken
//  out_    | out | out_tvalid/out_tready | out_tdata[72]: predicted_taken,
//          |     |                       |   prediction_correct, correct_total,
//          |     |                       |   branch_total
//
// Each word is accepted and its counter read in ST_IDLE (registered memory
// read); ST_UPDATE then writes the counter back and loads the result register.
// After reset the table is swept to zero, one entry a cycle, over all ENTRIES;
// in_tready stays low during the sweep.
// A waiting result does not block accept; the update waits only while the
// result register is still full and out_tready is low.
`timescale 1ns / 1ps

module bimodal_two_bit_predictor_top import bbp_pkg::*; #(
  parameter int ENTRIES = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] branch_address, [32] branch_taken, [39:33] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] predicted_taken, [1] prediction_correct, [33:2] correct_total,
  // [65:34] branch_total, [71:66] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  bbp_cmd_t  cmd;
  bbp_stat_t stat;

  bbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbp_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
